### design/bba_pkg.sv
// Package for the bitmap block allocator: sizes, status codes and payload types.
// Used by the channel interfaces and by the top level.
package bba_pkg;
  localparam int NUM_BLOCKS    = 4096;
  localparam int BLOCK_BYTES   = 16;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int BLK_W         = $clog2(NUM_BLOCKS);
  localparam int CNT_W         = $clog2(NUM_BLOCKS + 1);
  localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int BYTES_W       = 17;
  localparam int RSV_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 17;
  localparam int SHIFT_BB      = $clog2(BLOCK_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 1'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_LARGE = 2'd2
  } status_t;

  typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;

  typedef struct packed {
    logic                op;
    logic [BYTES_W-1:0]  size_bytes;
    logic [BYTES_W-1:0]  align_bytes;
    logic [11:0]         start_block;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [11:0]      granted_block;
    logic [12:0]      used_blocks;
  } rsp_t;
endpackage

### design/bba_req_if.sv
// Request channel interface: valid, ready and a request payload.
// Depends on bba_pkg.
interface bba_req_if;
  logic          valid;
  logic          ready;
  bba_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bba_rsp_if.sv
// Response channel interface: valid, ready and a response payload.
// Depends on bba_pkg.
interface bba_rsp_if;
  logic          valid;
  logic          ready;
  bba_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bitmap_block_allocator.sv
// Bitmap first-fit block allocator, top level.
// Depends on bba_pkg, bba_req_if and bba_rsp_if.
//
// A request arrives on req as one transaction: an allocate (size and alignment
// in bytes) or a free (first data block). Exactly one response transaction
// follows on rsp with status, granted block and the count of used data blocks.
// The configuration port writes reserved_blocks (index 0) and max_alloc_bytes
// (index 1); the user must write only while the block is idle (unenforced).
// One bit-test unit walks the bitmap one block at a time, each through a read state
// and a write state: an allocate tests the header of each candidate, then its data
// blocks, then marks the header and data blocks; a free reads the header and clears
// it and its data blocks. The header test of each candidate and each bit set or cleared goes through the
// same bitmap read-modify-write path, so cost grows with the blocks touched.
// Requests are taken one at a time; req.ready is low from acceptance until the
// response transaction completes. A stalled response simply holds.
// After reset the bitmap is cleared word by word, all MAP_WORDS (128) words, during
// which no request is accepted; configuration writes are taken throughout.
module bitmap_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data,
  bba_req_if.sink                        req,
  bba_rsp_if.source                      rsp
);
  localparam int BW = bba_pkg::BLK_W;
  localparam int XW = BW + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_HDR, S_HDR_W, S_DATA, S_DATA_W,
    S_MARK, S_MARK_W, S_FREE_R, S_FREE_W, S_RESP
  } state_t;

  state_t state;
  logic [bba_pkg::MAP_WORD_BITS-1:0] bitmap [bba_pkg::MAP_WORDS];
  logic [bba_pkg::CNT_W-1:0] size_store [bba_pkg::NUM_BLOCKS];
  logic [bba_pkg::MAP_WORD_BITS-1:0] rd_word;
  logic [bba_pkg::CNT_W-1:0] size_rd;

  logic [bba_pkg::RSV_W-1:0]   reserved_blocks;
  logic [bba_pkg::BYTES_W-1:0] max_alloc_bytes;
  logic [bba_pkg::CNT_W-1:0]   used_count;

  bba_pkg::req_t rq;
  logic [XW-1:0]  cand, n_blk, a_blk, k, ptr, limit;
  logic [bba_pkg::WORD_IDX_W-1:0] clr_idx;
  logic [1:0]  status;
  logic [BW-1:0] grant;
  logic set_val;
  logic [bba_pkg::BYTES_W-1:0] pow2, align_eff;

  // Memory address for the bit-test unit.
  logic [BW-1:0] addr;
  assign addr = ptr[BW-1:0];
  logic in_region;
  assign in_region = (ptr < XW'(bba_pkg::NUM_BLOCKS));
  logic bit_used;
  assign bit_used = !in_region || rd_word[addr[bba_pkg::BIT_IDX_W-1:0]];

  always_comb begin
    pow2 = '0;
    for (int b = 0; b < bba_pkg::BYTES_W; b++) begin
      if (rq.size_bytes[b]) pow2 = bba_pkg::BYTES_W'(1) << b;
    end
    align_eff = (pow2 > rq.align_bytes) ? pow2 : rq.align_bytes;
  end

  always_ff @(posedge clk) begin
    rd_word <= bitmap[addr[BW-1:bba_pkg::BIT_IDX_W]];
    size_rd <= size_store[addr];
    if (state == S_CLEAR) begin
      bitmap[clr_idx] <= '0;
    end else if ((state == S_MARK_W || state == S_FREE_W) && in_region) begin
      bitmap[addr[BW-1:bba_pkg::BIT_IDX_W]] <=
        rd_word & ~(bba_pkg::MAP_WORD_BITS'(1) <<
        addr[bba_pkg::BIT_IDX_W-1:0]) | ({bba_pkg::MAP_WORD_BITS{set_val}} &
        (bba_pkg::MAP_WORD_BITS'(1) << addr[bba_pkg::BIT_IDX_W-1:0]));
    end
    if (state == S_MARK_W && ptr == cand - XW'(1)) begin
      size_store[addr] <= n_blk[bba_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      reserved_blocks <= bba_pkg::RSV_W'(1);
      max_alloc_bytes <= bba_pkg::BYTES_W'(65536);
      used_count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == bba_pkg::CFG_RESERVED) reserved_blocks <= cfg_data[bba_pkg::RSV_W-1:0];
        else if (cfg_idx == bba_pkg::CFG_MAX) max_alloc_bytes <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + bba_pkg::WORD_IDX_W'(1);
          if (clr_idx == bba_pkg::WORD_IDX_W'(bba_pkg::MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            rq <= req.data;
            ptr <= XW'(req.data.start_block) - XW'(1);
            state <= S_PREP;
          end
        end
        S_PREP: begin
          status <= bba_pkg::ST_NOFIT;
          grant <= '0;
          if (rq.op == bba_pkg::OP_FREE) begin
            if (rq.start_block == '0) state <= S_RESP;
            else state <= S_FREE_R;
          end else if (rq.size_bytes > max_alloc_bytes || rq.align_bytes > max_alloc_bytes) begin
            status <= bba_pkg::ST_LARGE;
            state <= S_RESP;
          end else begin
            n_blk <= (rq.size_bytes == '0) ? XW'(1) :
                     XW'(({1'b0, rq.size_bytes} +
                          (bba_pkg::BYTES_W + 1)'(bba_pkg::BLOCK_BYTES - 1))
                         >> bba_pkg::SHIFT_BB);
            a_blk <= (align_eff == '0) ? XW'(1) :
                     XW'(({1'b0, align_eff} +
                          (bba_pkg::BYTES_W + 1)'(bba_pkg::BLOCK_BYTES - 1))
                         >> bba_pkg::SHIFT_BB);
            cand <= XW'(reserved_blocks) + XW'(1);
            ptr <= XW'(reserved_blocks);
            state <= S_HDR;
          end
        end
        S_HDR: begin
          if (cand >= XW'(bba_pkg::NUM_BLOCKS) || cand + n_blk > XW'(bba_pkg::NUM_BLOCKS))
            state <= S_RESP;
          else state <= S_HDR_W;
        end
        S_HDR_W: begin
          if (bit_used) begin
            cand <= cand + a_blk;
            ptr <= cand + a_blk - XW'(1);
            state <= S_HDR;
          end else begin
            ptr <= cand;
            k <= '0;
            state <= S_DATA;
          end
        end
        S_DATA: state <= S_DATA_W;
        S_DATA_W: begin
          if (bit_used) begin
            cand <= cand + a_blk;
            ptr <= cand + a_blk - XW'(1);
            state <= S_HDR;
          end else if (k + XW'(1) == n_blk) begin
            ptr <= cand - XW'(1);
            limit <= cand + n_blk;
            set_val <= 1'b1;
            state <= S_MARK;
          end else begin
            k <= k + XW'(1);
            ptr <= ptr + XW'(1);
            state <= S_DATA;
          end
        end
        S_MARK: state <= set_val ? S_MARK_W : S_FREE_W;
        S_MARK_W: begin
          if (ptr + XW'(1) == limit) begin
            status <= bba_pkg::ST_OK;
            grant <= cand[BW-1:0];
            used_count <= used_count + n_blk[bba_pkg::CNT_W-1:0];
            state <= S_RESP;
          end else begin
            ptr <= ptr + XW'(1);
            state <= S_MARK;
          end
        end
        S_FREE_R: begin
          if (!bit_used) state <= S_RESP;
          else begin
            status <= bba_pkg::ST_OK;
            n_blk <= XW'(size_rd);
            limit <= ptr + XW'(1) + XW'(size_rd);
            used_count <= (XW'(size_rd) > XW'(used_count)) ? '0 : used_count - size_rd;
            set_val <= 1'b0;
            state <= S_FREE_W;
          end
        end
        S_FREE_W: begin
          if (ptr + XW'(1) >= limit || !in_region) state <= S_RESP;
          else begin
            ptr <= ptr + XW'(1);
            state <= S_MARK;
          end
        end
        S_RESP: begin
          if (!rsp.valid) begin
            rsp.valid <= 1'b1;
            rsp.data <= '{status, grant, used_count};
          end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while a response is pending");
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != bba_pkg::ST_OK |-> rsp.data.granted_block == '0)
    else $error("grant not zero on error");
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used_count <= bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS)) else $error("used count overflow");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped");
endmodule
